FILE: rtl/core/abld_pkg.sv
// ----------------------------------------------------------------------------
// abld_pkg
// Shared types and constants of the analog button ladder debouncer:
// register indexes, reset values, button codes and the event record.
// ----------------------------------------------------------------------------
package abld_pkg;

  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned REG_IDX_BITS = 3;

  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam reg_idx_t REG_STABLE_DELTA = 3'd0;
  localparam reg_idx_t REG_CHANGE_DELTA = 3'd1;
  localparam reg_idx_t REG_SELECT_ABOVE = 3'd2;
  localparam reg_idx_t REG_NONE_ABOVE   = 3'd3;
  localparam reg_idx_t REG_LEFT_ABOVE   = 3'd4;
  localparam reg_idx_t REG_DOWN_ABOVE   = 3'd5;
  localparam reg_idx_t REG_UP_ABOVE     = 3'd6;
  localparam reg_idx_t REG_RIGHT_BELOW  = 3'd7;

  // Reset values before truncation to the sample width.
  localparam int unsigned REG_RESET [NUM_REGS] = '{
    10, 100, 4080, 2900, 2400, 1700, 750, 100
  };

  typedef enum logic [2:0] {
    BTN_NONE   = 3'd0,
    BTN_SELECT = 3'd1,
    BTN_LEFT   = 3'd2,
    BTN_DOWN   = 3'd3,
    BTN_UP     = 3'd4,
    BTN_RIGHT  = 3'd5
  } btn_t;

  typedef struct packed {
    btn_t button;
    logic pressed;
  } evt_t;

endpackage

FILE: rtl/core/abld_cfg.sv
// ----------------------------------------------------------------------------
// abld_cfg
// Configuration register file: delta limits and ladder thresholds.
// ----------------------------------------------------------------------------
module abld_cfg #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_we,
  input  abld_pkg::reg_idx_t                               cfg_index,
  input  logic [SAMPLE_BITS-1:0]                           cfg_wdata,
  output logic [abld_pkg::NUM_REGS-1:0][SAMPLE_BITS-1:0]   regs
);
  import abld_pkg::*;

  logic [NUM_REGS-1:0][SAMPLE_BITS-1:0] regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= SAMPLE_BITS'(REG_RESET[i]);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STABLE_DELTA: regs_r[REG_STABLE_DELTA] <= cfg_wdata;
        REG_CHANGE_DELTA: regs_r[REG_CHANGE_DELTA] <= cfg_wdata;
        REG_SELECT_ABOVE: regs_r[REG_SELECT_ABOVE] <= cfg_wdata;
        REG_NONE_ABOVE:   regs_r[REG_NONE_ABOVE]   <= cfg_wdata;
        REG_LEFT_ABOVE:   regs_r[REG_LEFT_ABOVE]   <= cfg_wdata;
        REG_DOWN_ABOVE:   regs_r[REG_DOWN_ABOVE]   <= cfg_wdata;
        REG_UP_ABOVE:     regs_r[REG_UP_ABOVE]     <= cfg_wdata;
        REG_RIGHT_BELOW:  regs_r[REG_RIGHT_BELOW]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

FILE: rtl/core/abld_eval.sv
// ----------------------------------------------------------------------------
// abld_eval
// Debounce state and event logic: stability check, level change check,
// threshold decode and press/release event generation.
// ----------------------------------------------------------------------------
module abld_eval #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             fire,
  input  logic [SAMPLE_BITS-1:0]                           sample,
  input  logic [abld_pkg::NUM_REGS-1:0][SAMPLE_BITS-1:0]   regs,
  output logic                                             evt_valid,
  output abld_pkg::evt_t                                   evt
);
  import abld_pkg::*;

  logic [SAMPLE_BITS-1:0] last_sample_r, last_sample_nxt;
  logic [SAMPLE_BITS-1:0] stable_level_r, stable_level_nxt;
  btn_t                   cur_btn_r, cur_btn_nxt;

  logic [SAMPLE_BITS-1:0] gap_last;
  logic [SAMPLE_BITS-1:0] gap_level;
  logic                   take_level;
  logic                   decoded;
  btn_t                   dec_btn;

  always_comb begin
    gap_last  = (sample > last_sample_r) ? sample - last_sample_r
                                         : last_sample_r - sample;
    gap_level = (sample > stable_level_r) ? sample - stable_level_r
                                          : stable_level_r - sample;
    take_level = (gap_last < regs[REG_STABLE_DELTA]) &&
                 (gap_level > regs[REG_CHANGE_DELTA]);

    // Thresholds are checked top-down; the first match wins.
    decoded = 1'b1;
    dec_btn = BTN_NONE;
    if (sample > regs[REG_SELECT_ABOVE]) begin
      dec_btn = BTN_SELECT;
    end else if (sample > regs[REG_NONE_ABOVE]) begin
      dec_btn = BTN_NONE;
    end else if (sample > regs[REG_LEFT_ABOVE]) begin
      dec_btn = BTN_LEFT;
    end else if (sample > regs[REG_DOWN_ABOVE]) begin
      dec_btn = BTN_DOWN;
    end else if (sample > regs[REG_UP_ABOVE]) begin
      dec_btn = BTN_UP;
    end else if (sample < regs[REG_RIGHT_BELOW]) begin
      dec_btn = BTN_RIGHT;
    end else begin
      decoded = 1'b0;
    end

    evt_valid   = take_level && decoded && (dec_btn != cur_btn_r);
    // A decode of no button reports the release of the button held so far.
    evt.button  = (dec_btn == BTN_NONE) ? cur_btn_r : dec_btn;
    evt.pressed = (dec_btn != BTN_NONE);

    last_sample_nxt  = sample;
    stable_level_nxt = take_level ? sample : stable_level_r;
    cur_btn_nxt      = evt_valid ? dec_btn : cur_btn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r  <= '0;
      stable_level_r <= '0;
      cur_btn_r      <= BTN_NONE;
    end else if (fire) begin
      last_sample_r  <= last_sample_nxt;
      stable_level_r <= stable_level_nxt;
      cur_btn_r      <= cur_btn_nxt;
    end
  end

endmodule

FILE: rtl/core/analog_button_ladder_debouncer.sv
// ----------------------------------------------------------------------------
// analog_button_ladder_debouncer
// Debounces and decodes ADC samples of a resistor-ladder keypad into
// button press and release transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_sample) takes one ADC sample per
//   transaction. A sample that is stable against the previous sample and
//   far enough from the last accepted level is decoded against the ladder
//   thresholds; a change of button yields one output transaction
//   (out_button, out_pressed = 1 for a press, 0 for a release).
//   Most samples yield no output transaction.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while the
//   block is idle; each write takes effect at the next clock edge.
//   An accepted sample is held in the input register, evaluated
//   combinationally and its event written to the output register.
//   Throughput: one sample per cycle while the receiver does not stall;
//   the evaluation between the input and output registers is combinational.
//   Reset loads the default thresholds and clears the debounce state to
//   "no button". When the receiver stalls with an event waiting, the
//   evaluation stage holds and in_ready drops once that stage is full.
// ----------------------------------------------------------------------------
module analog_button_ladder_debouncer #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_button,
  output logic                        out_pressed,
  input  logic                        cfg_we,
  input  logic [abld_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]      cfg_wdata
);
  import abld_pkg::*;

  logic [NUM_REGS-1:0][SAMPLE_BITS-1:0] regs;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r;
  evt_t                   out_evt_r;

  logic fire;
  logic evt_valid;
  evt_t evt;

  abld_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  abld_eval #(.SAMPLE_BITS(SAMPLE_BITS)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .sample    (s1_sample_r),
    .regs      (regs),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  // The staged sample is consumed whenever the output register can take
  // whatever it produces, event or not.
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= evt_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r <= in_sample;
    end
    if (fire && evt_valid) begin
      out_evt_r <= evt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_button  = out_evt_r.button;
  assign out_pressed = out_evt_r.pressed;

endmodule

FILE: tb/tb_analog_button_ladder_debouncer.sv
// ----------------------------------------------------------------------------
// tb_analog_button_ladder_debouncer
// Self-checking testbench for the keypad ladder debouncer. A local model
// of the debounce and threshold decode predicts every press and release
// transaction. The checker compares each output transaction in order.
// Directed samples cover the ladder bands, the undecodable gap, a zero
// stable delta and overlapping thresholds. Random runs of stable samples
// and noise follow under changing ladder settings, with idle cycles on both
// channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_analog_button_ladder_debouncer;
  timeunit 1ns;
  timeprecision 1ps;

  import abld_pkg::*;

  localparam int unsigned SB           = 12;
  localparam int unsigned MAX_SAMPLE   = (1 << SB) - 1;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [SB-1:0] in_sample = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [2:0]    out_button;
  logic          out_pressed;
  logic          cfg_we = 1'b0;
  reg_idx_t      cfg_index = '0;
  logic [SB-1:0] cfg_wdata = '0;

  // Local copy of the ladder registers and the debounce state.
  logic [SB-1:0] ladder_reg [NUM_REGS];
  logic [SB-1:0] cfg_next [NUM_REGS];
  logic [SB-1:0] prev_sample;
  logic [SB-1:0] held_level;
  btn_t          held_button;

  evt_t pending_events [$];
  evt_t head_evt;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int error_count = 0;
  int samples_sent = 0;
  int events_checked = 0;
  int configs_applied = 0;
  int unsigned cycle_count = 0;

  analog_button_ladder_debouncer #(.SAMPLE_BITS(SB)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_button  (out_button),
    .out_pressed (out_pressed),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still pending",
               cycle_count, pending_events.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: a requested hold-off wins over the random idle pattern.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch at cycle %0d: %s expected %0d got %0d",
             cycle_count, what, exp_v, got_v);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event, button", -1, out_button);
      end else begin
        head_evt = pending_events.pop_front();
        if (out_button !== 3'(head_evt.button))
          report_mismatch("button", head_evt.button, out_button);
        if (out_pressed !== head_evt.pressed)
          report_mismatch("pressed", head_evt.pressed, out_pressed);
        events_checked++;
      end
    end
  end

  function automatic logic [SB-1:0] abs_diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Debounce one sample, decode it on the ladder and queue any transaction.
  function automatic void decode_sample(input logic [SB-1:0] s);
    btn_t b;
    bit   hit;
    b   = BTN_NONE;
    hit = 1'b1;
    if (abs_diff(s, prev_sample) < ladder_reg[REG_STABLE_DELTA] &&
        abs_diff(s, held_level) > ladder_reg[REG_CHANGE_DELTA]) begin
      if (s > ladder_reg[REG_SELECT_ABOVE])     b = BTN_SELECT;
      else if (s > ladder_reg[REG_NONE_ABOVE])  b = BTN_NONE;
      else if (s > ladder_reg[REG_LEFT_ABOVE])  b = BTN_LEFT;
      else if (s > ladder_reg[REG_DOWN_ABOVE])  b = BTN_DOWN;
      else if (s > ladder_reg[REG_UP_ABOVE])    b = BTN_UP;
      else if (s < ladder_reg[REG_RIGHT_BELOW]) b = BTN_RIGHT;
      else hit = 1'b0;
      if (hit && b != held_button) begin
        if (b == BTN_NONE) pending_events.push_back('{button: held_button, pressed: 1'b0});
        else pending_events.push_back('{button: b, pressed: 1'b1});
        held_button = b;
      end
      held_level = s;
    end
    prev_sample = s;
  endfunction

  task automatic send_sample(input logic [SB-1:0] s);
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_sample(s);
    samples_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_pair(input logic [SB-1:0] s);
    send_sample(s);
    send_sample(s);
  endtask

  // Stop offering samples and wait until every predicted event has arrived.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= cfg_next[i];
      @(posedge clk);
      ladder_reg[i] = cfg_next[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    configs_applied++;
  endtask

  function automatic void default_config();
    for (int i = 0; i < NUM_REGS; i++) cfg_next[i] = SB'(REG_RESET[i]);
  endfunction

  function automatic void random_config(input int kind);
    int q [$];
    default_config();
    case (kind)
      0: begin
      end
      1: begin
        // Well-ordered ladder with random band edges.
        for (int i = 0; i < 5; i++) q.push_back($urandom_range(0, MAX_SAMPLE));
        q.rsort();
        cfg_next[REG_STABLE_DELTA] = SB'($urandom_range(2, 80));
        cfg_next[REG_CHANGE_DELTA] = SB'($urandom_range(0, 300));
        cfg_next[REG_SELECT_ABOVE] = SB'(q[0]);
        cfg_next[REG_NONE_ABOVE]   = SB'(q[1]);
        cfg_next[REG_LEFT_ABOVE]   = SB'(q[2]);
        cfg_next[REG_DOWN_ABOVE]   = SB'(q[3]);
        cfg_next[REG_UP_ABOVE]     = SB'(q[4]);
        cfg_next[REG_RIGHT_BELOW]  = SB'($urandom_range(0, q[4]));
      end
      2: begin
        cfg_next[REG_STABLE_DELTA] = SB'(MAX_SAMPLE);
        cfg_next[REG_CHANGE_DELTA] = '0;
      end
      3: begin
        // Only identical consecutive samples count as stable.
        cfg_next[REG_STABLE_DELTA] = SB'(1);
        cfg_next[REG_CHANGE_DELTA] = SB'($urandom_range(0, 200));
      end
      default: begin
        for (int i = 0; i < NUM_REGS; i++) cfg_next[i] = SB'($urandom_range(0, MAX_SAMPLE));
      end
    endcase
  endfunction

  // Mostly runs of near-identical samples around a random level, plus noise.
  task automatic send_random_stream(input int n_items);
    int sent;
    int target;
    int amp;
    int v;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        target  = $urandom_range(0, MAX_SAMPLE);
        amp     = (ladder_reg[REG_STABLE_DELTA] > 1) ? (ladder_reg[REG_STABLE_DELTA] - 1) / 2 : 0;
        if (amp > 40) amp = 40;
        run_len = $urandom_range(2, 4);
        for (int k = 0; k < run_len; k++) begin
          v = target + int'($urandom_range(0, 2 * amp)) - amp;
          if (v < 0) v = 0;
          if (v > int'(MAX_SAMPLE)) v = MAX_SAMPLE;
          send_sample(SB'(v));
          sent++;
        end
      end else begin
        send_sample(SB'($urandom_range(0, MAX_SAMPLE)));
        sent++;
      end
    end
  endtask

  task automatic test_default_ladder();
    default_config();
    apply_config();
    send_pair(SB'(MAX_SAMPLE));
    send_pair(SB'(3000));
    send_pair(SB'(2500));
    send_pair(SB'(2000));
    send_pair(SB'(1000));
    send_pair(SB'(50));
    // Between the up and right bands: the level moves, nothing is reported.
    send_pair(SB'(400));
    send_sample('0);
    send_sample(SB'(MAX_SAMPLE));
    drain_events();
  endtask

  task automatic test_zero_stable_delta();
    default_config();
    cfg_next[REG_STABLE_DELTA] = '0;
    apply_config();
    send_pair(SB'(3500));
    drain_events();
  endtask

  task automatic test_overlapping_thresholds();
    default_config();
    cfg_next[REG_SELECT_ABOVE] = SB'(2000);
    cfg_next[REG_NONE_ABOVE]   = SB'(2000);
    cfg_next[REG_LEFT_ABOVE]   = SB'(2000);
    cfg_next[REG_DOWN_ABOVE]   = SB'(2000);
    cfg_next[REG_UP_ABOVE]     = SB'(2000);
    cfg_next[REG_RIGHT_BELOW]  = SB'(MAX_SAMPLE);
    apply_config();
    send_pair(SB'(3000));
    send_pair(SB'(1000));
    drain_events();
    for (int i = REG_SELECT_ABOVE; i <= REG_UP_ABOVE; i++) cfg_next[i] = SB'(MAX_SAMPLE);
    cfg_next[REG_RIGHT_BELOW] = '0;
    apply_config();
    send_pair(SB'(2500));
    drain_events();
  endtask

  task automatic test_random_sweep(input int n_items, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int phase = 0; phase < 5; phase++) begin
      random_config((phase == 0) ? $urandom_range(1, 4) : phase);
      apply_config();
      send_random_stream(n_items / 5);
      drain_events();
    end
  endtask

  // Hold the receiver off while button changes keep arriving.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    default_config();
    apply_config();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      case (i % 4)
        0: send_pair(SB'(4090));
        1: send_pair(SB'(2000));
        2: send_pair(SB'(3000));
        default: send_pair(SB'(20));
      endcase
    end
    drain_events();
  endtask

  initial begin
    default_config();
    for (int i = 0; i < NUM_REGS; i++) ladder_reg[i] = cfg_next[i];
    prev_sample = '0;
    held_level  = '0;
    held_button = BTN_NONE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_ladder();
    test_zero_stable_delta();
    test_overlapping_thresholds();
    test_random_sweep(130, 17, 69);
    test_random_sweep(130, 69, 17);
    test_random_sweep(130, 0, 0);
    test_output_stall();

    if (pending_events.size() != 0)
      report_mismatch("events never seen", 0, pending_events.size());
    $display("run covered %0d samples, %0d checked transactions, %0d ladder settings",
             samples_sent, events_checked, configs_applied);
    $display("including both idle patterns, a long output stall and drained pauses");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", error_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/abld_pkg.sv
rtl/core/abld_cfg.sv
rtl/core/abld_eval.sv
rtl/core/analog_button_ladder_debouncer.sv
tb/tb_analog_button_ladder_debouncer.sv
